@@ src/dst_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the dimmable strobe timer.
package dst_pkg;

	localparam int unsigned CfgIndexW = 8;
	localparam int unsigned CfgDataW  = 16;

	typedef enum logic [1:0] {
		CMD_TICK       = 2'd0,
		CMD_START      = 2'd1,
		CMD_START_LVL  = 2'd2,
		CMD_STOP       = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_DIGITAL = 2'd1,
		KIND_PWM     = 2'd2
	} kind_t;

	localparam logic [CfgIndexW-1:0] REG_PERIOD      = 8'd0;
	localparam logic [CfgIndexW-1:0] REG_PULSE       = 8'd1;
	localparam logic [CfgIndexW-1:0] REG_ACTIVE_HIGH = 8'd2;
	localparam logic [CfgIndexW-1:0] REG_DIMMABLE    = 8'd3;

	localparam logic [15:0] PERIOD_RESET = 16'd500;
	localparam logic [15:0] PULSE_RESET  = 16'd50;
	localparam logic [7:0]  DUTY_FULL    = 8'd255;

	typedef struct packed {
		logic [15:0] period_ms;
		logic [15:0] pulse_ms;
		logic        active_high;
		logic        dimmable;
	} cfg_t;

	typedef struct packed {
		logic [7:0] duty;
		logic       pin_high;
		kind_t      write_kind;
	} result_t;

endpackage

@@ src/dimmable_strobe_timer.sv @@
`timescale 1ns / 1ps
// Top level of the dimmable strobe timer.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata: cmd, level
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata: write_kind, pin_high, duty
//   cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// Every command transaction yields one result transaction.
// One command can be taken every cycle while the skid stage is empty; the strobe state
// updates as the command is taken, and its result is registered in the output or skid stage.
// A two-entry output buffer keeps s_axis_tready high through one stalled result.
// Reset is asynchronous; configuration writes are always ready.
module dimmable_strobe_timer #(
	parameter int unsigned TIME_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,  // cmd[1:0], level[9:2], zero
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,  // write_kind[1:0], pin_high[2],
	                                                     // duty[10:3], zero
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dst_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [dst_pkg::CfgDataW-1:0]  cfg_data
);
	import dst_pkg::*;

	cfg_t    cfg;
	result_t core_res;
	result_t out_res;
	logic    in_accept;

	assign cfg_ready = 1'b1;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	dst_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dst_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (in_accept),
		.cmd    (cmd_t'(s_axis_tdata[1:0])),
		.level  (s_axis_tdata[9:2]),
		.res    (core_res)
	);

	dst_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (core_res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {5'b0, out_res.duty, out_res.pin_high, out_res.write_kind};

	// The input side only stalls while a result is already waiting at the output.
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result pending");

	// A command taken into an empty output stage shows up as a result next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !m_axis_tvalid) |=> m_axis_tvalid)
		else $error("accepted command produced no result");

	a_digital_no_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_res.write_kind != KIND_PWM) |-> out_res.duty == 8'd0)
		else $error("nonzero duty on a non-PWM result");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_res.write_kind == KIND_NONE ||
			out_res.write_kind == KIND_DIGITAL || out_res.write_kind == KIND_PWM))
		else $error("illegal write kind");

endmodule

@@ src/dst_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file of the dimmable strobe timer.
module dst_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [dst_pkg::CfgIndexW-1:0] wr_index,
	input  logic [dst_pkg::CfgDataW-1:0]  wr_data,
	output dst_pkg::cfg_t                 cfg
);
	import dst_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ms   <= PERIOD_RESET;
			cfg_q.pulse_ms    <= PULSE_RESET;
			cfg_q.active_high <= 1'b1;
			cfg_q.dimmable    <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PERIOD:      cfg_q.period_ms   <= wr_data;
				REG_PULSE:       cfg_q.pulse_ms    <= wr_data;
				REG_ACTIVE_HIGH: cfg_q.active_high <= wr_data[0];
				REG_DIMMABLE:    cfg_q.dimmable    <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/dst_core.sv @@
`timescale 1ns / 1ps
// Strobe state registers and the per-command next-state and result logic.
module dst_core #(
	parameter int unsigned TIME_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dst_pkg::cfg_t    cfg,
	input  logic             accept,
	input  dst_pkg::cmd_t    cmd,
	input  logic [7:0]       level,
	output dst_pkg::result_t res
);
	import dst_pkg::*;

	localparam int unsigned CmpW = (TIME_BITS > 16) ? TIME_BITS : 16;
	localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

	logic [TIME_BITS-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [15:0]          wait_q, wait_d;
	logic                 on_q, on_d;
	logic                 running_q, running_d;
	logic [7:0]           bright_q, bright_d;

	logic       steady;
	logic       phase_due;
	logic [7:0] on_duty;
	logic [7:0] off_duty;
	logic [7:0] new_on_duty;

	assign elapsed_inc = (elapsed_q == TimeMax) ? elapsed_q : elapsed_q + 1'b1;
	assign steady      = running_q && (cfg.period_ms <= cfg.pulse_ms);
	assign phase_due   = running_q && (CmpW'(elapsed_inc) >= CmpW'(wait_q));

	assign on_duty     = cfg.active_high ? bright_q : DUTY_FULL - bright_q;
	assign off_duty    = cfg.active_high ? 8'd0 : DUTY_FULL;
	assign new_on_duty = cfg.active_high ? level : DUTY_FULL - level;

	always_comb begin
		elapsed_d      = elapsed_q;
		wait_d         = wait_q;
		on_d           = on_q;
		running_d      = running_q;
		bright_d       = bright_q;
		res.write_kind = KIND_NONE;
		res.pin_high   = 1'b0;
		res.duty       = 8'd0;
		case (cmd)
			CMD_TICK: begin
				elapsed_d = elapsed_inc;
				if (steady) begin
					elapsed_d = '0;
					if (!on_q) begin
						on_d = 1'b1;
						if (cfg.dimmable) begin
							res.write_kind = KIND_PWM;
							res.duty       = on_duty;
						end else begin
							res.write_kind = KIND_DIGITAL;
							res.pin_high   = cfg.active_high;
						end
					end
				end else if (phase_due) begin
					elapsed_d = '0;
					on_d      = !on_q;
					wait_d    = on_q ? cfg.period_ms - cfg.pulse_ms : cfg.pulse_ms;
					if (cfg.dimmable) begin
						res.write_kind = KIND_PWM;
						res.duty       = on_q ? off_duty : on_duty;
					end else begin
						res.write_kind = KIND_DIGITAL;
						res.pin_high   = on_q ? !cfg.active_high : cfg.active_high;
					end
				end
			end
			CMD_START, CMD_START_LVL: begin
				// A level change while running and lit in dimmable mode updates the duty at once.
				if (cmd == CMD_START_LVL && level != bright_q) begin
					bright_d = level;
					if (running_q && cfg.dimmable && on_q) begin
						res.write_kind = KIND_PWM;
						res.duty       = new_on_duty;
					end
				end
				if (!running_q) begin
					wait_d    = '0;
					on_d      = 1'b0;
					running_d = 1'b1;
				end
			end
			CMD_STOP: begin
				running_d      = 1'b0;
				res.write_kind = KIND_DIGITAL;
				res.pin_high   = !cfg.active_high;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			wait_q    <= '0;
			on_q      <= 1'b0;
			running_q <= 1'b0;
			bright_q  <= '0;
		end else if (accept) begin
			elapsed_q <= elapsed_d;
			wait_q    <= wait_d;
			on_q      <= on_d;
			running_q <= running_d;
			bright_q  <= bright_d;
		end
	end

endmodule

@@ src/dst_out_buf.sv @@
`timescale 1ns / 1ps
// Output register with a skid stage for the result stream.
module dst_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dst_pkg::result_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output dst_pkg::result_t out_data
);
	import dst_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_free;

	assign in_ready = !skid_valid_q;
	assign out_free = out_ready || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_valid && in_ready) begin
			skid_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
